/* sv/scp_pkg.sv */
// ----------------------------------------------------------------------------
// scp_pkg
// Shared widths, defaults and item types for the stack permutation checker.
// ----------------------------------------------------------------------------
package scp_pkg;

   localparam int COACH_W         = 11;          // coach numbers and count register
   localparam int NEXT_W          = COACH_W + 1; // next incoming coach can reach 2**COACH_W
   localparam int MAX_COACHES_DEF = 1024;

   typedef struct packed {
      logic [COACH_W-1:0] target_coach;
      logic               last_in_sequence;
   } req_type;

   typedef struct packed {
      logic possible_so_far;
      logic sequence_done;
   } rsp_type;

endpackage

/* sv/scp_stack.sv */
// ----------------------------------------------------------------------------
// scp_stack
// Coach stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scp_stack #(
   parameter int DEPTH  = scp_pkg::MAX_COACHES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [scp_pkg::COACH_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [scp_pkg::COACH_W-1:0] rd_data
);

   logic [scp_pkg::COACH_W-1:0] mem [DEPTH];
   logic [scp_pkg::COACH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/stack_permutation_checker.sv */
// ----------------------------------------------------------------------------
// stack_permutation_checker
// Checks, item by item, whether a target coach order can be made from the
// ascending order 1..N through a single stack.
// ----------------------------------------------------------------------------
// One item is handled at a time. A target that passes straight through
// pushes the coaches below it onto the stack, one a cycle through the single
// write port of the stack RAM, and then finishes. A target taken off the
// stack needs one registered read of the stack top; a failing or already
// failed item goes straight to its finish step. A finished result sits in an
// output register, so the block takes the next item while it waits; it only
// holds in its final step if the previous result is still unclaimed. No
// clearing pass is needed after reset.
module stack_permutation_checker #(
   parameter int MAX_COACHES = scp_pkg::MAX_COACHES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  scp_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output scp_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [scp_pkg::COACH_W-1:0] csr_data
);

   localparam int COACH_W = scp_pkg::COACH_W;
   localparam int NEXT_W  = scp_pkg::NEXT_W;
   localparam int ADDR_W  = $clog2(MAX_COACHES);
   localparam int CNT_W   = $clog2(MAX_COACHES + 1);
   localparam int CAP_INT = (MAX_COACHES < 2**COACH_W) ? MAX_COACHES : 2**COACH_W - 1;
   localparam logic [COACH_W-1:0] CAP     = CAP_INT[COACH_W-1:0];
   localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_COACHES);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EVAL   = 5'b00010,
      ST_PUSH   = 5'b00100,
      ST_CHECK  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [COACH_W-1:0]    coach_count_ff, coach_count_in;
   logic [NEXT_W-1:0]     next_ff, next_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  failed_ff, failed_in;
   logic [COACH_W-1:0]    target_ff, target_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   scp_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic [COACH_W-1:0]    n_eff;
   logic [NEXT_W-1:0]     n_plus1;
   logic [NEXT_W-1:0]     target_ext;
   logic [CNT_W-1:0]      top_ptr;
   logic                  push_more;
   logic                  stack_wr_en;
   logic [COACH_W-1:0]    stack_rd_data;
   logic                  req_take;
   logic                  out_free;
   logic                  ok;

   assign n_eff      = (coach_count_ff > CAP) ? CAP : coach_count_ff;
   assign n_plus1    = {1'b0, n_eff} + NEXT_W'(1);
   assign target_ext = {1'b0, target_ff};
   assign top_ptr    = count_ff - CNT_W'(1);
   assign push_more  = next_ff < target_ext;
   assign stack_wr_en = (state_ff == ST_PUSH) && push_more && (count_ff < CNT_MAX);

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = !reset;

   // stack top is read every cycle; the address is steady through EVAL
   scp_stack #(
      .DEPTH  (MAX_COACHES),
      .ADDR_W (ADDR_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (next_ff[COACH_W-1:0]),
      .rd_addr (top_ptr[ADDR_W-1:0]),
      .rd_data (stack_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      coach_count_in = coach_count_ff;
      next_in        = next_ff;
      count_in       = count_ff;
      failed_in      = failed_ff;
      target_in      = target_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      ok             = !failed_ff;

      if (csr_valid && csr_ready) begin
         coach_count_in = csr_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               target_in = req_data.target_coach;
               last_in   = req_data.last_in_sequence;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (failed_ff) begin
               state_in = ST_FINISH;
            end else if (target_ff == '0 || target_ff > n_eff) begin
               failed_in = 1'b1;
               state_in  = ST_FINISH;
            end else if (target_ext >= next_ff) begin
               state_in = ST_PUSH;
            end else if (count_ff != '0) begin
               state_in = ST_CHECK;
            end else begin
               failed_in = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_PUSH: begin
            if (push_more) begin
               next_in = next_ff + NEXT_W'(1);
               if (count_ff < CNT_MAX) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end else begin
               next_in  = target_ext + NEXT_W'(1);
               state_in = ST_FINISH;
            end
         end
         ST_CHECK: begin
            if (stack_rd_data == target_ff) begin
               count_in = top_ptr;
            end else begin
               failed_in = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               if (last_ff) begin
                  if (next_ff != n_plus1 || count_ff != '0) begin
                     ok = 1'b0;
                  end
                  next_in   = NEXT_W'(1);
                  count_in  = '0;
                  failed_in = 1'b0;
               end
               rsp_data_in.possible_so_far = ok;
               rsp_data_in.sequence_done   = last_ff;
               rsp_valid_in                = 1'b1;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         coach_count_ff <= COACH_W'(1);
         next_ff        <= NEXT_W'(1);
         count_ff       <= '0;
         failed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         coach_count_ff <= coach_count_in;
         next_ff        <= next_in;
         count_ff       <= count_in;
         failed_ff      <= failed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/scp_checker.sv */
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks for the stack permutation checker, bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input scp_pkg::rsp_type rsp_data
);

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // every item spends at least an evaluate and a finish step inside
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall)
      else $error("input taken again too soon after an item");

   // a new result only appears at the end of an item's work
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item without work in progress");

   // a result cannot appear in the cycle straight after an item is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result item too early");

endmodule

bind stack_permutation_checker scp_checker u_scp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/tb_stack_permutation_checker.sv */
// ----------------------------------------------------------------------------
// tb_stack_permutation_checker
// Self-checking bench for the stack permutation checker. Coach orders that
// one stack can produce are sent, along with broken, short, open-ended and
// random ones, under a range of coach counts. A software copy of the stack
// predicts each verdict, and every result is compared in order.
// ----------------------------------------------------------------------------
module tb_stack_permutation_checker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COACH_W         = scp_pkg::COACH_W;
   localparam int NEXT_W          = scp_pkg::NEXT_W;
   localparam int MAX_COACHES_DEF = scp_pkg::MAX_COACHES_DEF;

   localparam int RANDOM_ITEMS = 800;
   localparam int TAIL_ITEMS   = 100;
   localparam int IDLE_LIMIT   = 6000;

   class verdict_board;
      logic [COACH_W-1:0] coach_count;
      logic [NEXT_W-1:0]  next_coach;
      logic [COACH_W-1:0] siding [MAX_COACHES_DEF];
      int unsigned        siding_depth;
      bit                 failed;
      scp_pkg::rsp_type   expected_verdicts [$];
      int                 errors;
      int                 verdicts_checked;

      function new();
         coach_count      = COACH_W'(1);
         errors           = 0;
         verdicts_checked = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         next_coach   = NEXT_W'(1);
         siding_depth = 0;
         failed       = 1'b0;
      endfunction

      function void note_target(scp_pkg::req_type item);
         int unsigned      n;
         int unsigned      tgt;
         scp_pkg::rsp_type verdict;
         n   = (coach_count > MAX_COACHES_DEF) ? MAX_COACHES_DEF : 32'(coach_count);
         tgt = 32'(item.target_coach);
         if (!failed) begin
            if (tgt < 1 || tgt > n) begin
               failed = 1'b1;
            end else if (tgt >= next_coach) begin
               // coaches ahead of the target go onto the siding
               while (next_coach < tgt) begin
                  if (siding_depth < MAX_COACHES_DEF) begin
                     siding[siding_depth] = next_coach[COACH_W-1:0];
                     siding_depth++;
                  end
                  next_coach++;
               end
               next_coach = NEXT_W'(tgt + 1);
            end else if (siding_depth > 0 && siding[siding_depth-1] == tgt) begin
               siding_depth--;
            end else begin
               failed = 1'b1;
            end
         end
         verdict.possible_so_far = !failed;
         verdict.sequence_done   = item.last_in_sequence;
         if (item.last_in_sequence) begin
            // a short order never empties the yard
            if (next_coach != n + 1 || siding_depth != 0) verdict.possible_so_far = 1'b0;
            clear_sequence();
         end
         expected_verdicts.push_back(verdict);
      endfunction

      function void check_verdict(scp_pkg::rsp_type got);
         scp_pkg::rsp_type want;
         if (expected_verdicts.size() == 0) begin
            $display("%0t: result with none expected, actual possible=%b done=%b",
                     $time, got.possible_so_far, got.sequence_done);
            errors++;
            return;
         end
         want = expected_verdicts.pop_front();
         verdicts_checked++;
         if (got.possible_so_far !== want.possible_so_far) begin
            $display("%0t: possible_so_far expected %b actual %b",
                     $time, want.possible_so_far, got.possible_so_far);
            errors++;
         end
         if (got.sequence_done !== want.sequence_done) begin
            $display("%0t: sequence_done expected %b actual %b",
                     $time, want.sequence_done, got.sequence_done);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   scp_pkg::req_type   req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   scp_pkg::rsp_type   rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [COACH_W-1:0] csr_data;

   verdict_board     board = new();
   scp_pkg::req_type plan [$];
   bit               gaps_on         = 1'b1;
   int               items_sent      = 0;
   int               sequences_sent  = 0;
   int               configs_written = 0;
   int               idle_cycles     = 0;

   stack_permutation_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result monitor and watchdog
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !reset) board.check_verdict(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // receiver back-pressure in bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (gaps_on && !reset && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(scp_pkg::req_type item);
      int unsigned gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_target(item);
      items_sent++;
   endtask

   task automatic send_plan();
      foreach (plan[i]) send_item(plan[i]);
      plan.delete();
      sequences_sent++;
   endtask

   // sender holds off until every verdict is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_verdicts.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_coach_count(int unsigned value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value[COACH_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.coach_count = value[COACH_W-1:0];
      configs_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_target(int unsigned target, bit last);
      scp_pkg::req_type item;
      item.target_coach     = target[COACH_W-1:0];
      item.last_in_sequence = last;
      plan.push_back(item);
   endfunction

   function automatic void mark_last();
      scp_pkg::req_type item;
      item = plan[plan.size()-1];
      item.last_in_sequence = 1'b1;
      plan[plan.size()-1] = item;
   endfunction

   // random push/pop walk: the pop order is always stackable
   function automatic void plan_stackable(int n);
      int held [$];
      int next_up;
      next_up = 1;
      while (next_up <= n || held.size() != 0) begin
         if (next_up <= n && (held.size() == 0 || $urandom_range(0, 1) == 1)) begin
            held.push_back(next_up);
            next_up++;
         end else begin
            add_target(held.pop_back(), 1'b0);
         end
      end
      mark_last();
   endfunction

   function automatic void plan_sequence(int unsigned count);
      int               n;
      int               kind;
      int               a;
      int               b;
      int unsigned      t;
      scp_pkg::req_type item_a;
      scp_pkg::req_type item_b;
      n    = (count > MAX_COACHES_DEF) ? MAX_COACHES_DEF : count;
      kind = $urandom_range(0, 9);
      if (n == 0 || n > 24 || kind == 9) begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
               0:       t = $urandom_range(0, 2047);
               1:       t = $urandom_range(0, n + 1);
               2:       t = n;
               default: t = $urandom_range(1, 4);
            endcase
            add_target(t, 1'b0);
         end
         mark_last();
      end else begin
         plan_stackable(n);
         a = $urandom_range(0, plan.size() - 1);
         b = $urandom_range(0, plan.size() - 1);
         case (kind)
            6: begin
               item_a = plan[a];
               item_b = plan[b];
               t = 32'(item_a.target_coach);
               item_a.target_coach = item_b.target_coach;
               item_b.target_coach = t[COACH_W-1:0];
               plan[a] = item_a;
               plan[b] = item_b;
            end
            7: begin
               // repeated or out-of-range coach
               item_a = plan[a];
               item_a.target_coach = COACH_W'($urandom_range(0, n + 1));
               plan[a] = item_a;
            end
            8: begin
               if (plan.size() > 1) begin
                  repeat ($urandom_range(1, plan.size() - 1)) void'(plan.pop_back());
                  // half of them stay open and run on into the next order
                  if ($urandom_range(0, 1) == 1) mark_last();
               end
            end
            default: ;
         endcase
      end
   endfunction

   initial begin
      int unsigned stop_at;
      int unsigned count;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // count of one after reset: the only coach passes through
      add_target(1, 1'b1); send_plan();
      add_target(0, 1'b1); send_plan();
      set_coach_count(2047);
      add_target(2047, 1'b1); send_plan();
      // deepest siding, then a short order
      add_target(1024, 1'b0); add_target(1023, 1'b0);
      add_target(1022, 1'b0); add_target(1021, 1'b1); send_plan();
      set_coach_count(0);
      add_target(1, 1'b1); send_plan();
      set_coach_count(5);
      add_target(3, 1'b0); add_target(2, 1'b0); add_target(4, 1'b0);
      add_target(1, 1'b0); add_target(5, 1'b1); send_plan();
      add_target(2, 1'b0); add_target(2, 1'b0); add_target(5, 1'b1); send_plan();
      // coach 1 is buried under 2, and the fail sticks
      add_target(3, 1'b0); add_target(1, 1'b0); add_target(5, 1'b1); send_plan();
      // count shrinks in the middle of an order
      add_target(2, 1'b0); send_plan();
      set_coach_count(3);
      add_target(3, 1'b0); add_target(1, 1'b1); send_plan();

      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: begin
               case ($urandom_range(0, 4))
                  0:       count = 0;
                  1:       count = 2047;
                  2:       count = MAX_COACHES_DEF;
                  3:       count = MAX_COACHES_DEF + 1;
                  default: count = $urandom_range(25, 2047);
               endcase
            end
            1:       count = 1;
            default: count = $urandom_range(2, 16);
         endcase
         set_coach_count(count);
         repeat ($urandom_range(3, 8)) begin
            gaps_on = (items_sent + TAIL_ITEMS < stop_at);
            plan_sequence(count);
            send_plan();
         end
      end

      drain();
      $display("%0d items in %0d orders over %0d coach count writes, %0d verdicts checked",
               items_sent, sequences_sent, configs_written, board.verdicts_checked);
      $display("orders covered: stackable, swapped, repeated, out of range, short, open, random");
      if (board.errors == 0 && board.expected_verdicts.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
